@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/cwk_pkg.sv @@
`default_nettype none

package cwk_pkg;

  localparam int VERTICES  = 8;
  localparam int MAX_EDGES = 15;

  localparam int VTX_W   = 3;
  localparam int EDGE_W  = 4;
  localparam int WALK_W  = 43;
  localparam int ADJ_W   = 64;
  localparam int ADDR_W  = 4;

  typedef logic [WALK_W-1:0] walk_t;
  typedef walk_t [VERTICES-1:0] vec_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

`default_nettype wire

@@ rtl/cwk_step.sv @@
`default_nettype none

// One vector step: every lane i sums the entries of the current vector at the
// columns where row i of the adjacency matrix has an edge. Sums wrap at the
// walk width, which only drops bits above the result field. Each lane adds its
// terms as a balanced tree so the depth grows with log2 of the vertex count.
module cwk_step (
  input  wire logic [cwk_pkg::ADJ_W-1:0] adjacency,
  input  wire cwk_pkg::vec_t             vec,
  output cwk_pkg::vec_t                  vec_next
);

  always_comb begin
    cwk_pkg::walk_t part [cwk_pkg::VERTICES];
    vec_next = '0;
    for (int i = 0; i < cwk_pkg::VERTICES; i++) begin
      for (int a = 0; a < cwk_pkg::VERTICES; a++) begin
        part[a] = adjacency[i * cwk_pkg::VERTICES + a] ? vec[a] : '0;
      end
      for (int span = 1; span < cwk_pkg::VERTICES; span = span * 2) begin
        for (int a = 0; a + span < cwk_pkg::VERTICES; a = a + 2 * span) begin
          part[a] = part[a] + part[a + span];
        end
      end
      vec_next[i] = part[0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/count_walks_k_edges.sv @@
// An accepted item runs its vector steps and then registers walk_count; no new
// item is taken until it is done. One vector step per cycle goes through the
// shared step unit; in_stall is high while an item runs.
// A finished result waits in the output register while the next item runs.
// Reset (rst, synchronous) clears the adjacency register, the sequencer and
// the output valid.
`default_nettype none
`include "assert_macros.svh"

module count_walks_k_edges (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cwk_pkg::VTX_W-1:0]     source_vertex,
  input  wire logic [cwk_pkg::VTX_W-1:0]     dest_vertex,
  input  wire logic [cwk_pkg::EDGE_W-1:0]    edge_count,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cwk_pkg::WALK_W-1:0]         walk_count,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cwk_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [cwk_pkg::ADJ_W-1:0]     pwdata,
  output logic [cwk_pkg::ADJ_W-1:0]          prdata,
  output logic                               pready
);

  logic [cwk_pkg::ADJ_W-1:0]  adjacency;
  cwk_pkg::state_t            state;
  cwk_pkg::vec_t              vec;
  cwk_pkg::vec_t              vec_next;
  logic [cwk_pkg::EDGE_W-1:0] remaining;
  logic [cwk_pkg::VTX_W-1:0]  source;
  logic                       in_xfer;
  logic                       out_xfer;
  logic                       out_free;
  logic                       in_range;
  logic                       reg_hit;

  // The single register sits at byte address 0; the next 8-byte slot holds
  // nothing.
  assign reg_hit = (paddr[cwk_pkg::ADDR_W-1] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? adjacency : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      adjacency <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      adjacency <= pwdata;
    end
  end

  assign in_stall = (state != cwk_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range = (int'(source_vertex) < cwk_pkg::VERTICES) &&
                    (int'(dest_vertex) < cwk_pkg::VERTICES) &&
                    (int'(edge_count) <= cwk_pkg::MAX_EDGES);

  cwk_step u_step (
    .adjacency (adjacency),
    .vec       (vec),
    .vec_next  (vec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cwk_pkg::ST_IDLE;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        cwk_pkg::ST_IDLE: begin
          if (in_xfer) begin
            state     <= cwk_pkg::ST_RUN;
            remaining <= in_range ? edge_count : '0;
          end
        end
        cwk_pkg::ST_RUN: begin
          if (remaining != '0) begin
            remaining <= remaining - 1'b1;
          end else if (out_free) begin
            state <= cwk_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= cwk_pkg::ST_IDLE;
        end
      endcase

      if (state == cwk_pkg::ST_RUN && remaining == '0 && out_free) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The vector starts as the unit vector of the destination; an item out of
  // range starts from all zeros so that it finishes with a zero count.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      source <= source_vertex;
      for (int i = 0; i < cwk_pkg::VERTICES; i++) begin
        vec[i] <= (in_range && int'(dest_vertex) == i) ?
                  cwk_pkg::walk_t'(1) : '0;
      end
    end else if (state == cwk_pkg::ST_RUN && remaining != '0) begin
      vec <= vec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cwk_pkg::ST_RUN && remaining == '0 && out_free) begin
      walk_count <= vec[source];
    end
  end

  `ASSERT_CLK(a_countdown, clk, rst,
    (state == cwk_pkg::ST_RUN && remaining != '0) |=> (remaining == $past(remaining) - 1'b1))
  `ASSERT_CLK(a_accept_starts_run, clk, rst,
    in_xfer |=> (state == cwk_pkg::ST_RUN))
  `ASSERT_CLK(a_result_after_run, clk, rst,
    $rose(out_valid) |-> $past(state == cwk_pkg::ST_RUN && remaining == '0))
  `ASSERT_ALWAYS(a_reset_clears_out, clk,
    rst |=> !out_valid)

endmodule

`default_nettype wire
